@@ rtl/drpi_pkg.sv @@
package drpi_pkg;

    // Field and register widths
    localparam int WHEEL_W    = 16;
    localparam int SUM_W      = WHEEL_W + 1;
    localparam int YAW_W      = 24;
    localparam int SCALE_W    = 24;
    localparam int TSTEP_W    = 32;
    localparam int POS_W      = 32;
    localparam int ANGLE_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Multiply-accumulate datapath
    localparam int MAC_A_W   = 45;
    localparam int MAC_B_W   = 16;
    localparam int MAC_P_W   = MAC_A_W + MAC_B_W + 1;
    localparam int ACC_W     = 64;
    localparam int VEL_W     = 29;
    localparam int DIST_W    = 45;
    localparam int CX0_W     = 46;

    // Rotation datapath
    localparam int ROT_XY_W  = 48;
    localparam int ROT_Z_W   = 34;
    localparam int ROT_IDX_W = 5;

    localparam logic [SCALE_W-1:0]  SPEED_SCALE_RST = 24'd219502;
    localparam logic [TSTEP_W-1:0]  TIME_STEP_RST   = 32'd4294967;
    localparam logic [MAC_B_W-1:0]  INV_GAIN_Q16    = 16'd39797;
    localparam logic [ANGLE_W-1:0]  QUARTER_TURN    = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0]  HALF_TURN       = 32'h8000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN     = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_SCALE = 1'b0,
        REG_TIME_STEP   = 1'b1
    } cfg_reg_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_V_LO,
        ST_V_HI,
        ST_D_LO,
        ST_D_HI,
        ST_GAIN,
        ST_H_LO,
        ST_H_HI,
        ST_ROT,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic en;
        logic first;
        logic hi;
    } mac_ctrl_t;

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [ROT_IDX_W-1:0] idx;
    } rot_ctrl_t;

    // atan(2^-i) in 2^-32 turn units, rounded to nearest
    function automatic logic [ANGLE_W-1:0] atan_lut(input logic [ROT_IDX_W-1:0] i);
        logic [ANGLE_W-1:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/drpi_channels.sv @@
interface drpi_tick_if
    import drpi_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic signed [WHEEL_W-1:0] left_wheel_speed;
    logic signed [WHEEL_W-1:0] right_wheel_speed;
    logic signed [YAW_W-1:0]   yaw_rate;

    modport source (
        output valid, left_wheel_speed, right_wheel_speed, yaw_rate,
        input  ready
    );
    modport sink (
        input  valid, left_wheel_speed, right_wheel_speed, yaw_rate,
        output ready
    );
endinterface

interface drpi_pose_if
    import drpi_pkg::*;
    ;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANGLE_W-1:0]      heading;
    logic                    saturated;

    modport source (
        output valid, pos_x, pos_y, heading, saturated,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, heading, saturated,
        output ready
    );
endinterface

@@ rtl/drpi_mac.sv @@
module drpi_mac
    import drpi_pkg::*;
(
    input  logic                      clk,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [MAC_A_W-1:0] a,
    input  logic [MAC_B_W-1:0]        b,
    output logic [ACC_W-1:0]          acc
);

    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          acc_next;
    logic signed [MAC_B_W:0]   b_s;
    logic signed [MAC_P_W-1:0] prod;
    logic [ACC_W-1:0]          term;

    // Signed by unsigned half-word product, optionally weighted by 2^16
    always_comb
    begin
        b_s  = signed'({1'b0, b});
        prod = a * b_s;
        if (ctrl.hi)
        begin
            term = ACC_W'({prod, 16'h0000});
        end
        else
        begin
            term = ACC_W'(prod);
        end
        if (ctrl.first)
        begin
            acc_next = term;
        end
        else
        begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

@@ rtl/drpi_cordic.sv @@
module drpi_cordic
    import drpi_pkg::*;
(
    input  logic                       clk,
    input  rot_ctrl_t                  ctrl,
    input  logic signed [CX0_W-1:0]    x_init,
    input  logic [ANGLE_W-1:0]         angle,
    output logic signed [ROT_XY_W-1:0] x,
    output logic signed [ROT_XY_W-1:0] y
);

    logic signed [ROT_XY_W-1:0] x_reg, x_next;
    logic signed [ROT_XY_W-1:0] y_reg, y_next;
    logic signed [ROT_Z_W-1:0]  z_reg, z_next;
    logic [ANGLE_W-1:0]         angle_q;
    logic [ANGLE_W-1:0]         h;
    logic                       flip;
    logic signed [ROT_XY_W-1:0] x_ld;
    logic signed [ROT_XY_W-1:0] xs;
    logic signed [ROT_XY_W-1:0] ys;
    logic [ROT_Z_W-1:0]         at;

    always_comb
    begin
        // Fold left half-plane onto the right by a half-turn pre-rotation
        angle_q = angle + QUARTER_TURN;
        flip    = angle_q[ANGLE_W-1];
        x_ld    = ROT_XY_W'(x_init);
        h       = angle;
        if (flip)
        begin
            x_ld = -ROT_XY_W'(x_init);
            h    = angle - HALF_TURN;
        end

        // One micro-rotation per step
        xs = x_reg >>> ctrl.idx;
        ys = y_reg >>> ctrl.idx;
        at = ROT_Z_W'(atan_lut(ctrl.idx));

        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctrl.load)
        begin
            x_next = x_ld;
            y_next = '0;
            z_next = ROT_Z_W'(signed'(h));
        end
        else if (ctrl.step)
        begin
            if (!z_reg[ROT_Z_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - signed'(at);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + signed'(at);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

@@ rtl/dead_reckoning_pose_integrator.sv @@
// Dead-reckoning pose integrator for a differential-drive vehicle.
// tick channel: one beat per time step carrying both wheel speeds (Q12.4 rpm)
//   and the yaw rate (2^-16 turn/s). ready is high only while the block is idle.
// pose channel: one beat per tick beat with the new position (Q16.16 m,
//   saturating), the new heading (binary angle) and the clip flag.
// Config port: cfg_we/cfg_index/cfg_data write speed_scale (index 0) or
//   time_step (index 1); write only while no tick is in flight.
// Sequence: after the tick beat is accepted, the shared multiply-accumulate unit
//   computes speed, distance, gain correction and heading increment; then the
//   shared shift-add rotator runs CORDIC_STEPS steps, one per cycle; then the
//   update state commits the new pose to the output register once it is free.
// A new tick is accepted only after the previous one has been committed, so
//   ticks pass through the single rotator one at a time.
// A finished pose sits in the output register; the next tick is accepted while
//   it waits, and the block then holds in its update cycle until the pose beat
//   is taken, so a stalled receiver loses nothing.
// Reset: position and heading clear to zero, registers take their defaults,
//   no pose beat is pending.
module dead_reckoning_pose_integrator
    import drpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    drpi_tick_if.sink             tick,
    drpi_pose_if.source           pose,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [ROT_IDX_W-1:0] LAST_STEP = ROT_IDX_W'(CORDIC_STEPS - 1);

    state_t                    state_reg, state_next;
    logic [SCALE_W-1:0]        scale_reg;
    logic [TSTEP_W-1:0]        tstep_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [YAW_W-1:0]   yaw_reg;
    logic signed [MAC_A_W-1:0] opa_reg, opa_next;
    logic [ROT_IDX_W-1:0]      cnt_reg, cnt_next;
    logic signed [POS_W-1:0]   pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [ANGLE_W-1:0]        head_reg, head_next;
    logic                      sat_reg, sat_next;
    logic                      valid_reg;

    logic                       accept;
    logic                       commit;
    mac_ctrl_t                  mac_ctrl;
    logic signed [MAC_A_W-1:0]  mac_a;
    logic [MAC_B_W-1:0]         mac_b;
    logic [ACC_W-1:0]           acc;
    rot_ctrl_t                  rot_ctrl;
    logic signed [ROT_XY_W-1:0] rot_x;
    logic signed [ROT_XY_W-1:0] rot_y;
    logic signed [VEL_W-1:0]    vel;
    logic signed [DIST_W-1:0]   travel;
    logic signed [CX0_W-1:0]    cx0;
    logic signed [POS_W-1:0]    dx;
    logic signed [POS_W-1:0]    dy;
    logic signed [POS_W+1:0]    sx;
    logic signed [POS_W+1:0]    sy;

    assign accept     = tick.valid && tick.ready;
    assign tick.ready = (state_reg == ST_IDLE);

    // Floor shifts of the accumulator are plain bit selects
    assign vel    = acc[VEL_W+11:12];
    assign travel = acc[DIST_W+15:16];
    assign cx0    = acc[CX0_W+15:16];

    drpi_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (acc)
    );

    drpi_cordic u_cordic (
        .clk    (clk),
        .ctrl   (rot_ctrl),
        .x_init (cx0),
        .angle  (head_reg),
        .x      (rot_x),
        .y      (rot_y)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        opa_next   = opa_reg;
        cnt_next   = cnt_reg;
        mac_ctrl   = '0;
        mac_a      = '0;
        mac_b      = '0;
        rot_ctrl   = '0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    state_next = ST_V_LO;
                end
            end
            ST_V_LO:
            begin
                mac_ctrl   = '{en: 1'b1, first: 1'b1, hi: 1'b0};
                mac_a      = MAC_A_W'(sum_reg);
                mac_b      = scale_reg[15:0];
                state_next = ST_V_HI;
            end
            ST_V_HI:
            begin
                mac_ctrl   = '{en: 1'b1, first: 1'b0, hi: 1'b1};
                mac_a      = MAC_A_W'(sum_reg);
                mac_b      = MAC_B_W'(scale_reg[SCALE_W-1:16]);
                state_next = ST_D_LO;
            end
            ST_D_LO:
            begin
                mac_ctrl   = '{en: 1'b1, first: 1'b1, hi: 1'b0};
                mac_a      = MAC_A_W'(vel);
                mac_b      = tstep_reg[15:0];
                opa_next   = MAC_A_W'(vel);
                state_next = ST_D_HI;
            end
            ST_D_HI:
            begin
                mac_ctrl   = '{en: 1'b1, first: 1'b0, hi: 1'b1};
                mac_a      = opa_reg;
                mac_b      = tstep_reg[31:16];
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                mac_ctrl   = '{en: 1'b1, first: 1'b1, hi: 1'b0};
                mac_a      = travel;
                mac_b      = INV_GAIN_Q16;
                state_next = ST_H_LO;
            end
            ST_H_LO:
            begin
                rot_ctrl.load = 1'b1;
                cnt_next      = '0;
                mac_ctrl      = '{en: 1'b1, first: 1'b1, hi: 1'b0};
                mac_a         = MAC_A_W'(yaw_reg);
                mac_b         = tstep_reg[15:0];
                state_next    = ST_H_HI;
            end
            ST_H_HI:
            begin
                mac_ctrl   = '{en: 1'b1, first: 1'b0, hi: 1'b1};
                mac_a      = MAC_A_W'(yaw_reg);
                mac_b      = tstep_reg[31:16];
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                rot_ctrl.step = 1'b1;
                rot_ctrl.idx  = cnt_reg;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg + ROT_IDX_W'(1);
                end
            end
            ST_UPD:
            begin
                // Wait for the output register to free up
                if (!valid_reg || pose.ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Saturating position update, wrapping heading update
    always_comb
    begin
        dx        = rot_x[POS_W+15:16];
        dy        = rot_y[POS_W+15:16];
        sx        = (POS_W+2)'(pos_x_reg) + (POS_W+2)'(dx);
        sy        = (POS_W+2)'(pos_y_reg) + (POS_W+2)'(dy);
        sat_next  = 1'b0;
        pos_x_next = sx[POS_W-1:0];
        pos_y_next = sy[POS_W-1:0];
        if (sx > (POS_W+2)'(POS_MAX))
        begin
            pos_x_next = POS_MAX;
            sat_next   = 1'b1;
        end
        else if (sx < (POS_W+2)'(POS_MIN))
        begin
            pos_x_next = POS_MIN;
            sat_next   = 1'b1;
        end
        if (sy > (POS_W+2)'(POS_MAX))
        begin
            pos_y_next = POS_MAX;
            sat_next   = 1'b1;
        end
        else if (sy < (POS_W+2)'(POS_MIN))
        begin
            pos_y_next = POS_MIN;
            sat_next   = 1'b1;
        end
        head_next = head_reg + acc[ANGLE_W+15:16];
    end

    // Control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            head_reg  <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (commit)
            begin
                valid_reg <= 1'b1;
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                head_reg  <= head_next;
                sat_reg   <= sat_next;
            end
            else if (pose.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SPEED_SCALE_RST;
            tstep_reg <= TIME_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                REG_TIME_STEP:   tstep_reg <= cfg_data[TSTEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Tick capture and operand hold
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= SUM_W'(tick.left_wheel_speed) + SUM_W'(tick.right_wheel_speed);
            yaw_reg <= tick.yaw_rate;
        end
        opa_reg <= opa_next;
    end

    assign pose.valid     = valid_reg;
    assign pose.pos_x     = pos_x_reg;
    assign pose.pos_y     = pos_y_reg;
    assign pose.heading   = head_reg;
    assign pose.saturated = sat_reg;

endmodule

@@ rtl/drpi_checker.sv @@
module drpi_checker
    import drpi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    tick_valid,
    input  logic                    tick_ready,
    input  logic                    pose_valid,
    input  logic                    pose_ready,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic [ANGLE_W-1:0]      heading,
    input  logic                    saturated
);

    // A stalled pose beat holds its payload
    a_pose_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_ready |=> pose_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(heading) && $stable(saturated))
        else $error("pose beat changed while stalled");

    // One tick at a time: busy right after a tick beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick accepted while busy");

    // No pose can appear right after a tick beat
    a_no_early_pose: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !$rose(pose_valid))
        else $error("pose produced too early");

    // A clip leaves a coordinate on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && saturated |-> pos_x == POS_MAX || pos_x == POS_MIN
            || pos_y == POS_MAX || pos_y == POS_MIN)
        else $error("saturated set with no coordinate at a rail");

endmodule

bind dead_reckoning_pose_integrator drpi_checker u_drpi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .pose_valid (pose.valid),
    .pose_ready (pose.ready),
    .pos_x      (pose.pos_x),
    .pos_y      (pose.pos_y),
    .heading    (pose.heading),
    .saturated  (pose.saturated)
);
